[sv/latency_sample_statistics_macros.svh]
// Assertion macros used by the checker file.
`ifndef LATENCY_SAMPLE_STATISTICS_MACROS_SVH
`define LATENCY_SAMPLE_STATISTICS_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LSS_ASSERT_IMPL(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define LSS_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

[sv/lss_pkg.sv]
`default_nettype none
package lss_pkg;

  localparam int DEPTH_DEF       = 1024;
  localparam int SAMPLE_BITS_DEF = 24;

  localparam int TIME_W     = 64;
  localparam int SEQ_W      = 64;
  localparam int VALUE_W    = 24;
  localparam int KIND_W     = 4;
  localparam int SQ_W       = 64;
  localparam int IN_DATA_W  = 192;
  localparam int OUT_DATA_W = 88;
  localparam int OUT_USER_W = 5;

  // Percentile points and their divisor.
  localparam int PCT_50  = 50;
  localparam int PCT_75  = 75;
  localparam int PCT_99  = 99;
  localparam int PCT_DIV = 100;
  localparam int PCT_W   = 7;

  // Rounded-up reciprocal of the percentile divisor, scaled by 2^PCT_SHIFT.
  // The truncated product is exact for every dividend below 2^30.
  localparam int unsigned PCT_RECIP = 32'd42949673;
  localparam int          PCT_SHIFT = 32;

  typedef enum logic [KIND_W-1:0] {
    KIND_SAMPLE = 4'd0,
    KIND_COUNT  = 4'd1,
    KIND_MIN    = 4'd2,
    KIND_MEAN   = 4'd3,
    KIND_P50    = 4'd4,
    KIND_P75    = 4'd5,
    KIND_P99    = 4'd6,
    KIND_MAX    = 4'd7,
    KIND_STDEV  = 4'd8
  } stat_kind_e;

  // Control shared by every cell of the sorted chain.
  typedef struct packed {
    logic ins;
    logic rot;
  } cell_ctl_t;

endpackage
`default_nettype wire

[sv/lss_cell.sv]
`default_nettype none
module lss_cell #(
  parameter int W     = 24,
  parameter int IDX   = 0,
  parameter int CNT_W = 11
) (
  input  wire                    clk_i,
  input  wire lss_pkg::cell_ctl_t ctl_i,
  input  wire  [CNT_W-1:0]       count_i,
  input  wire  [W-1:0]           ins_val_i,
  input  wire  [W-1:0]           left_val_i,
  input  wire                    left_gt_i,
  input  wire  [W-1:0]           right_val_i,
  output logic [W-1:0]           val_o,
  output logic                   gt_o
);
  import lss_pkg::*;

  logic [W-1:0] val_q;
  logic         active;
  logic         at_end;

  // This cell holds a sample when its index is below the count.
  assign active = count_i > CNT_W'(IDX);
  assign at_end = count_i == CNT_W'(IDX);
  assign gt_o   = active && (val_q > ins_val_i);
  assign val_o  = val_q;

  // Rotate toward cell zero, or make room for an inserted sample.
  always_ff @(posedge clk_i) begin
    if (ctl_i.rot) begin
      val_q <= right_val_i;
    end else if (ctl_i.ins && (active || at_end)) begin
      if (left_gt_i) begin
        val_q <= left_val_i;
      end else if (gt_o || at_end) begin
        val_q <= ins_val_i;
      end
    end
  end

endmodule
`default_nettype wire

[sv/lss_div.sv]
`default_nettype none
module lss_div #(
  parameter int DVS_W = 11
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        start_i,
  input  wire  [lss_pkg::SQ_W-1:0]   dividend_i,
  input  wire  [DVS_W-1:0]           divisor_i,
  output logic                       done_o,
  output logic [lss_pkg::SQ_W-1:0]   quo_o
);
  import lss_pkg::*;

  localparam int CW = $clog2(SQ_W);

  logic [SQ_W-1:0]  quo_q;
  logic [DVS_W-1:0] rem_q;
  logic [DVS_W-1:0] dvs_q;
  logic [CW-1:0]    cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [DVS_W:0]   trial;
  logic             fits;

  assign trial  = {rem_q, quo_q[SQ_W-1]};
  assign fits   = trial >= {1'b0, dvs_q};
  assign done_o = done_q;
  assign quo_o  = quo_q;

  // Restoring division, one quotient bit per cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        quo_q  <= dividend_i;
        rem_q  <= '0;
        dvs_q  <= divisor_i;
      end else if (busy_q) begin
        if (fits) begin
          rem_q <= DVS_W'(trial - {1'b0, dvs_q});
        end else begin
          rem_q <= trial[DVS_W-1:0];
        end
        quo_q <= {quo_q[SQ_W-2:0], fits};
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(SQ_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

[sv/lss_sqrt.sv]
`default_nettype none
module lss_sqrt (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        start_i,
  input  wire  [lss_pkg::SQ_W-1:0]   value_i,
  output logic                       done_o,
  output logic [lss_pkg::SQ_W/2-1:0] root_o
);
  import lss_pkg::*;

  logic [SQ_W-1:0] v_q;
  logic [SQ_W-1:0] res_q;
  logic [SQ_W-1:0] bit_q;
  logic            busy_q;
  logic            done_q;
  logic [SQ_W-1:0] trial;

  assign trial  = res_q + bit_q;
  assign done_o = done_q;
  assign root_o = res_q[SQ_W/2-1:0];

  // Digit-by-digit square root, two radicand bits per cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        v_q    <= value_i;
        res_q  <= '0;
        bit_q  <= SQ_W'(1) << (SQ_W - 2);
      end else if (busy_q) begin
        if (v_q >= trial) begin
          v_q   <= v_q - trial;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
        if (bit_q == SQ_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

[sv/latency_sample_statistics.sv]
// Latency statistics over a sorted chain of sample cells. An add item (tuser
// low) has its latency captured and saturated, then inserted in sorted
// position in one step by the whole cell chain unless the store is full (then
// flagged as dropped), and echoed with its sequence. A report item (tuser
// high) computes the three percentile indices by reciprocal multiplication,
// runs two serial divisions (mean and mean square), one multiply, a square
// root and a full rotation of the DEPTH-cell chain, then hands out eight
// items ending with tlast. An empty store reports a single count item of
// zero. The store keeps its contents across reports.
`default_nettype none
module latency_sample_statistics #(
  parameter int DEPTH       = lss_pkg::DEPTH_DEF,
  parameter int SAMPLE_BITS = lss_pkg::SAMPLE_BITS_DEF
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             s_axis_tvalid,
  output logic                            s_axis_tready,
  // sequence_req[63:0], receive_ns[127:64], sent_time_ns[191:128]
  input  wire  [lss_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // action[0]
  input  wire                             s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  wire                             m_axis_tready,
  // stat_value[23:0], echo_sequence[87:24]
  output logic [lss_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // stat_kind[3:0], dropped[4]
  output logic [lss_pkg::OUT_USER_W-1:0]  m_axis_tuser,
  output logic                            m_axis_tlast
);
  import lss_pkg::*;

  localparam int SB    = SAMPLE_BITS;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);
  localparam int SUM_W = SB + CNT_W;
  localparam int DVS_W = CNT_W;
  localparam int PRD_W = CNT_W + PCT_W;
  localparam int SCL_W = PRD_W + PCT_SHIFT;
  localparam int SQR_W = 2 * SB;
  localparam logic [TIME_W-1:0] SAMPLE_MAX = (TIME_W'(1) << SB) - TIME_W'(1);

  typedef enum logic [3:0] {
    S_IDLE, S_ADD, S_EMPTY, S_PCT, S_DIV_GO, S_DIV, S_MUL, S_VAR,
    S_SQ_GO, S_SQ, S_ROT, S_EMIT
  } state_e;

  state_e            state_q;
  logic [CNT_W-1:0]  count_q;
  logic [SUM_W-1:0]  sum_q;
  logic [SQ_W-1:0]   sqsum_q;
  logic [SB-1:0]     diff_q;
  logic [SEQ_W-1:0]  seq_q;
  logic              job_q;
  logic [2:0]        emit_q;
  logic [IDX_W-1:0]  rot_q;
  logic [SB-1:0]     mean_q, min_q, p50_q, p75_q, p99_q, max_q;
  logic [SQ_W-1:0]   msq_q, ms_q, var_q;
  logic [IDX_W-1:0]  i50_q, i75_q, i99_q;
  logic [SQ_W/2-1:0] stdev_q;
  logic              div_go_q, sq_go_q;

  logic                  out_free;
  logic                  out_load;
  logic [TIME_W-1:0]     raw_diff;
  logic [SB-1:0]         diff_in;
  logic [SQR_W-1:0]      diff_wide;
  logic [SQR_W-1:0]      mean_wide;
  logic [SQ_W-1:0]       dividend;
  logic [DVS_W-1:0]      divisor;
  logic                  div_done, sq_done;
  logic [SQ_W-1:0]       quo;
  logic [SQ_W/2-1:0]     root;
  cell_ctl_t             ctl;
  logic [SB-1:0]         cell_val [DEPTH];
  logic                  cell_gt  [DEPTH];
  logic [IDX_W-1:0]      last_idx;
  logic [TIME_W-1:0]     emit_val;
  stat_kind_e            emit_kind;

  // Sorted index floor(n * pct / 100) by multiplying with the reciprocal.
  function automatic logic [IDX_W-1:0] pct_index(input logic [CNT_W-1:0] n,
                                                 input logic [PCT_W-1:0] pct);
    logic [PRD_W-1:0] prod;
    logic [SCL_W-1:0] scaled;
    prod   = PRD_W'(n) * PRD_W'(pct);
    scaled = SCL_W'(prod) * SCL_W'(PCT_RECIP);
    return IDX_W'(scaled >> PCT_SHIFT);
  endfunction

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign out_load      = out_free && ((state_q == S_ADD) || (state_q == S_EMPTY) ||
                                      (state_q == S_EMIT));
  assign s_axis_tready = state_q == S_IDLE;
  assign last_idx      = IDX_W'(count_q - 1'b1);
  assign diff_wide     = SQR_W'(diff_q);
  assign mean_wide     = SQR_W'(mean_q);

  // Latency with saturation for negative or oversized differences.
  assign raw_diff = s_axis_tdata[127:64] - s_axis_tdata[191:128];
  assign diff_in  = ((s_axis_tdata[127:64] < s_axis_tdata[191:128]) ||
                     (raw_diff > SAMPLE_MAX)) ? '1 : raw_diff[SB-1:0];

  // Operands of the current division job: the sum first, then the square sum.
  always_comb begin
    divisor = DVS_W'(count_q);
    if (job_q) begin
      dividend = sqsum_q;
    end else begin
      dividend = SQ_W'(sum_q);
    end
  end

  lss_div #(.DVS_W(DVS_W)) u_div (
    .clk_i, .rst_ni, .start_i(div_go_q), .dividend_i(dividend), .divisor_i(divisor),
    .done_o(div_done), .quo_o(quo)
  );

  lss_sqrt u_sqrt (
    .clk_i, .rst_ni, .start_i(sq_go_q), .value_i(var_q), .done_o(sq_done), .root_o(root)
  );

  // Chain control: insert on an add, rotate during the report scan.
  assign ctl.ins = (state_q == S_ADD) && out_free && (count_q < CNT_W'(DEPTH));
  assign ctl.rot = state_q == S_ROT;

  // The sorted chain of sample cells.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    lss_cell #(.W(SB), .IDX(i), .CNT_W(CNT_W)) u_cell (
      .clk_i,
      .ctl_i       (ctl),
      .count_i     (count_q),
      .ins_val_i   (diff_q),
      .left_val_i  ((i == 0) ? SB'(0) : cell_val[(i == 0) ? 0 : i - 1]),
      .left_gt_i   ((i == 0) ? 1'b0 : cell_gt[(i == 0) ? 0 : i - 1]),
      .right_val_i (cell_val[(i + 1) % DEPTH]),
      .val_o       (cell_val[i]),
      .gt_o        (cell_gt[i])
    );
  end

  // Report item selected by the emit counter.
  always_comb begin
    emit_val  = TIME_W'(count_q);
    emit_kind = KIND_COUNT;
    unique case (emit_q)
      3'd0: begin emit_val = TIME_W'(count_q); emit_kind = KIND_COUNT; end
      3'd1: begin emit_val = TIME_W'(min_q);   emit_kind = KIND_MIN;   end
      3'd2: begin emit_val = TIME_W'(mean_q);  emit_kind = KIND_MEAN;  end
      3'd3: begin emit_val = TIME_W'(p50_q);   emit_kind = KIND_P50;   end
      3'd4: begin emit_val = TIME_W'(p75_q);   emit_kind = KIND_P75;   end
      3'd5: begin emit_val = TIME_W'(p99_q);   emit_kind = KIND_P99;   end
      3'd6: begin emit_val = TIME_W'(max_q);   emit_kind = KIND_MAX;   end
      default: begin emit_val = TIME_W'(stdev_q); emit_kind = KIND_STDEV; end
    endcase
  end

  // Sequencer, accumulators and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      count_q       <= '0;
      sum_q         <= '0;
      sqsum_q       <= '0;
      m_axis_tvalid <= 1'b0;
      div_go_q      <= 1'b0;
      sq_go_q       <= 1'b0;
      job_q         <= 1'b0;
      emit_q        <= '0;
      rot_q         <= '0;
    end else begin
      div_go_q <= state_q == S_DIV_GO;
      sq_go_q  <= state_q == S_SQ_GO;
      if (m_axis_tvalid && m_axis_tready && !out_load) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            diff_q <= diff_in;
            seq_q  <= s_axis_tdata[63:0];
            if (!s_axis_tuser) begin
              state_q <= S_ADD;
            end else if (count_q == '0) begin
              state_q <= S_EMPTY;
            end else begin
              state_q <= S_PCT;
            end
          end
        end
        S_ADD: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tlast  <= 1'b1;
            m_axis_tdata  <= {seq_q, VALUE_W'(TIME_W'(diff_q))};
            m_axis_tuser  <= {!ctl.ins, KIND_SAMPLE};
            if (ctl.ins) begin
              count_q <= count_q + 1'b1;
              sum_q   <= sum_q + SUM_W'(diff_q);
              sqsum_q <= sqsum_q + SQ_W'(diff_wide * diff_wide);
            end
            state_q <= S_IDLE;
          end
        end
        S_EMPTY: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tlast  <= 1'b1;
            m_axis_tdata  <= '0;
            m_axis_tuser  <= {1'b0, KIND_COUNT};
            state_q       <= S_IDLE;
          end
        end
        S_PCT: begin
          i50_q   <= pct_index(count_q, PCT_W'(PCT_50));
          i75_q   <= pct_index(count_q, PCT_W'(PCT_75));
          i99_q   <= pct_index(count_q, PCT_W'(PCT_99));
          job_q   <= 1'b0;
          state_q <= S_DIV_GO;
        end
        S_DIV_GO: begin
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            if (job_q) begin
              ms_q    <= quo;
              state_q <= S_MUL;
            end else begin
              mean_q  <= quo[SB-1:0];
              job_q   <= 1'b1;
              state_q <= S_DIV_GO;
            end
          end
        end
        S_MUL: begin
          msq_q   <= SQ_W'(mean_wide * mean_wide);
          state_q <= S_VAR;
        end
        S_VAR: begin
          var_q   <= (ms_q > msq_q) ? ms_q - msq_q : '0;
          state_q <= S_SQ_GO;
        end
        S_SQ_GO: begin
          state_q <= S_SQ;
        end
        S_SQ: begin
          if (sq_done) begin
            stdev_q <= root;
            rot_q   <= '0;
            state_q <= S_ROT;
          end
        end
        S_ROT: begin
          // Cell zero shows the sorted entry at the rotation index.
          if (rot_q == '0)      min_q <= cell_val[0];
          if (rot_q == i50_q)   p50_q <= cell_val[0];
          if (rot_q == i75_q)   p75_q <= cell_val[0];
          if (rot_q == i99_q)   p99_q <= cell_val[0];
          if (rot_q == last_idx) max_q <= cell_val[0];
          rot_q <= rot_q + 1'b1;
          if (rot_q == IDX_W'(DEPTH - 1)) begin
            emit_q  <= '0;
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tlast  <= emit_q == 3'd7;
            m_axis_tdata  <= {SEQ_W'(0), emit_val[VALUE_W-1:0]};
            m_axis_tuser  <= {1'b0, emit_kind};
            emit_q        <= emit_q + 1'b1;
            if (emit_q == 3'd7) begin
              state_q <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[sv/lss_checker.sv]
`default_nettype none
`include "latency_sample_statistics_macros.svh"
module lss_checker (
  input wire                             clk_i,
  input wire                             rst_ni,
  input wire                             s_axis_tvalid,
  input wire                             s_axis_tready,
  input wire                             m_axis_tvalid,
  input wire                             m_axis_tready,
  input wire [lss_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  input wire [lss_pkg::OUT_USER_W-1:0]   m_axis_tuser,
  input wire                             m_axis_tlast
);
  import lss_pkg::*;

  // A pending item stays offered until taken.
  `LSS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  // Each input item is worked on alone.
  `LSS_ASSERT_NEXT(a_one_at_a_time, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  // A sample echo is always a run of one.
  `LSS_ASSERT_IMPL(a_sample_last, clk_i, rst_ni, m_axis_tvalid && (m_axis_tuser[3:0] == KIND_SAMPLE), m_axis_tlast)
  // Report items carry no sequence and no drop flag.
  `LSS_ASSERT_IMPL(a_report_clean, clk_i, rst_ni, m_axis_tvalid && (m_axis_tuser[3:0] != KIND_SAMPLE), (m_axis_tdata[87:24] == 64'd0) && !m_axis_tuser[4])

endmodule

bind latency_sample_statistics lss_checker u_lss_checker (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .m_axis_tvalid, .m_axis_tready,
  .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
);
`default_nettype wire

[verif/tb.sv]
`timescale 1ns / 100ps
`default_nettype none

// Scoreboard: keeps its own copy of the sample store and predicts results.
class latency_scoreboard;
  localparam int STORE_DEPTH = 1024;
  localparam logic [23:0] SAT_MAX = 24'hFFFFFF;

  logic [23:0] samples[$];
  logic [63:0] lat_sum;
  logic [63:0] sq_sum;
  logic [87:0] exp_data[$];
  logic [4:0]  exp_user[$];
  logic        exp_last[$];
  int          errors;

  function new();
    lat_sum = '0;
    sq_sum = '0;
    errors = 0;
  endfunction

  function void push_result(lss_pkg::stat_kind_e kind, logic [63:0] value,
                            logic [63:0] seq, logic drop, logic lst);
    exp_data.insert(exp_data.size(), {seq, value[23:0]});
    exp_user.insert(exp_user.size(), {drop, kind});
    exp_last.insert(exp_last.size(), lst);
  endfunction

  function logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Note one accepted input item and queue what it should produce.
  function void note_input(logic action, logic [63:0] seq, logic [63:0] rx_ns,
                           logic [63:0] sent);
    logic [63:0] diff;
    logic [23:0] sorted[$];
    logic [63:0] n, mean, msq, sq, var_v;
    if (action == 1'b0) begin
      diff = (rx_ns < sent) ? 64'(SAT_MAX) : rx_ns - sent;
      if (diff > 64'(SAT_MAX)) diff = 64'(SAT_MAX);
      if (samples.size() < STORE_DEPTH) begin
        samples.insert(samples.size(), diff[23:0]);
        lat_sum = lat_sum + diff;
        sq_sum = sq_sum + diff * diff;
        push_result(lss_pkg::KIND_SAMPLE, diff, seq, 1'b0, 1'b1);
      end else begin
        push_result(lss_pkg::KIND_SAMPLE, diff, seq, 1'b1, 1'b1);
      end
      return;
    end
    n = samples.size();
    if (n == 0) begin
      push_result(lss_pkg::KIND_COUNT, 0, 0, 1'b0, 1'b1);
      return;
    end
    sorted = samples;
    sorted.sort();
    mean = lat_sum / n;
    sq = sq_sum / n;
    msq = mean * mean;
    var_v = (sq > msq) ? sq - msq : 0;
    push_result(lss_pkg::KIND_COUNT, n, 0, 1'b0, 1'b0);
    push_result(lss_pkg::KIND_MIN, sorted[0], 0, 1'b0, 1'b0);
    push_result(lss_pkg::KIND_MEAN, mean, 0, 1'b0, 1'b0);
    push_result(lss_pkg::KIND_P50, sorted[(n * 50) / 100], 0, 1'b0, 1'b0);
    push_result(lss_pkg::KIND_P75, sorted[(n * 75) / 100], 0, 1'b0, 1'b0);
    push_result(lss_pkg::KIND_P99, sorted[(n * 99) / 100], 0, 1'b0, 1'b0);
    push_result(lss_pkg::KIND_MAX, sorted[n - 1], 0, 1'b0, 1'b0);
    push_result(lss_pkg::KIND_STDEV, int_sqrt(var_v), 0, 1'b0, 1'b1);
  endfunction

  task report_mismatch(string what, logic [87:0] got, logic [87:0] want);
    $display("MISMATCH %s: got %h expected %h", what, got, want);
    errors++;
  endtask

  // Compare one accepted result with the oldest expectation.
  task check_result(logic [87:0] data, logic [4:0] user, logic lst);
    logic [87:0] wd;
    logic [4:0]  wu;
    logic        wl;
    if (exp_data.size() == 0) begin
      report_mismatch("unexpected item", data, 0);
      return;
    end
    wd = exp_data.pop_front();
    wu = exp_user.pop_front();
    wl = exp_last.pop_front();
    if (user[3:0] != wu[3:0]) report_mismatch("stat_kind", user[3:0], wu[3:0]);
    if (data[23:0] != wd[23:0]) report_mismatch("stat_value", data[23:0], wd[23:0]);
    if (data[87:24] != wd[87:24]) report_mismatch("echo_sequence", data[87:24], wd[87:24]);
    if (user[4] != wu[4]) report_mismatch("dropped", user[4], wu[4]);
    if (lst != wl) report_mismatch("last", lst, wl);
  endtask
endclass

module tb;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 2000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [lss_pkg::IN_DATA_W-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [lss_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic [lss_pkg::OUT_USER_W-1:0] m_axis_tuser;
  logic m_axis_tlast;

  latency_scoreboard latency_sb = new();
  int  idle_cycles = 0;
  bit  hold_sink = 1'b0;
  bit  stimulus_done = 1'b0;

  always #10 clk_i = ~clk_i;

  latency_sample_statistics u_dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
  );

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Sample both handshakes at the rising edge; watchdog on stalls.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        latency_sb.note_input(s_axis_tuser, s_axis_tdata[63:0], s_axis_tdata[127:64],
                              s_axis_tdata[191:128]);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        latency_sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          hold_sink) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout");
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Receiver: random ready with gaps; a long hold-off when requested.
  initial begin
    int g;
    forever begin
      @(negedge clk_i);
      if (hold_sink) begin
        m_axis_tready <= 1'b0;
      end else begin
        g = gap_len();
        if (g == 0 || stimulus_done) begin
          m_axis_tready <= 1'b1;
        end else begin
          m_axis_tready <= 1'b0;
          repeat (g - 1) @(negedge clk_i);
        end
      end
    end
  end

  // Offer one item and wait until it is accepted.
  task automatic send_item(logic action, logic [63:0] seq, logic [63:0] rx_ns,
                           logic [63:0] sent, bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= action;
    s_axis_tdata <= {sent, rx_ns, seq};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic add_latency(logic [63:0] lat, bit gaps);
    logic [63:0] sent;
    logic [63:0] seq;
    sent = {$urandom, $urandom} >> $urandom_range(1, 40);
    seq = {$urandom, $urandom};
    send_item(1'b0, seq, sent + lat, sent, gaps);
  endtask

  task automatic wait_results_done();
    s_axis_tvalid <= 1'b0;
    while (latency_sb.exp_data.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    logic [63:0] lat;
    int r;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: empty report, extremes, negative and wrapped differences.
    send_item(1'b1, {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom}, 0);
    send_item(1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 64'd0, 0);
    send_item(1'b0, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 0);
    send_item(1'b0, 64'h5555_AAAA_5555_AAAA, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 0);
    send_item(1'b0, 64'hAAAA_5555_AAAA_5555, 64'd1000, 64'd1001, 0);
    send_item(1'b0, 64'd7, 64'h0000_0000_00FF_FFFF, 64'd0, 0);
    send_item(1'b0, 64'd8, 64'h0000_0000_0100_0000, 64'd0, 0);
    send_item(1'b0, 64'd9, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE, 0);
    send_item(1'b1, 0, 0, 0, 0);
    add_latency(64'd1, 0);
    add_latency(64'd5000, 0);
    send_item(1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
              64'hFFFF_FFFF_FFFF_FFFF, 0);

    // Sender pauses until every expected result has come.
    wait_results_done();

    // Long receiver hold-off while the sender keeps offering items.
    hold_sink = 1'b1;
    fork
      begin
        repeat (300) @(negedge clk_i);
        hold_sink = 1'b0;
      end
      begin
        repeat (12) add_latency($urandom_range(0, 200000), 0);
      end
    join

    // Random part: mostly typical latencies, some extremes and reports.
    repeat (250) begin
      r = $urandom_range(0, 99);
      if (r < 5) begin
        send_item(1'b1, {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom}, 1);
      end else if (r < 15) begin
        send_item(1'b0, {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom}, 1);
      end else begin
        lat = $urandom_range(0, 99) < 5 ? 64'(~24'h0) + $urandom_range(0, 2) :
              64'($urandom_range(0, 500000));
        add_latency(lat, 1);
      end
    end
    send_item(1'b1, 0, 0, 0, 1);
    s_axis_tvalid <= 1'b0;
    stimulus_done = 1'b1;

    wait_results_done();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (latency_sb.errors == 0 && latency_sb.exp_data.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

`default_nettype wire
